// ===== design/ccl_pkg.sv =====
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types, codes and constants of the coin and start lamp controller.
// ----------------------------------------------------------------------------
package ccl_pkg;

    // Default sizes; the top level can override them within their ranges
    localparam int GROUPS_DEFAULT      = 8;
    localparam int MAX_BUTTONS_DEFAULT = 8;
    // Widest group the masks are padded to before output truncation
    localparam int MAX_BUTTONS_LIMIT   = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [1:0] {
        OP_PRESS      = 2'd0,
        OP_TICK       = 2'd1,
        OP_ACTIVATE   = 2'd2,
        OP_DEACTIVATE = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COINS_PER_CREDIT = 3'd0,
        CFG_SINGLE_MODE      = 3'd1,
        CFG_ONCE_ONLY        = 3'd2,
        CFG_ALWAYS_ON        = 3'd3,
        CFG_BLINK_FRAMES     = 3'd4,
        CFG_BUTTONS_IN_GROUP = 3'd5
    } cfg_index_t;

    localparam logic [7:0] COINS_PER_CREDIT_RST = 8'd1;
    localparam logic [7:0] BLINK_FRAMES_RST     = 8'd6;
    localparam logic [3:0] BUTTONS_IN_GROUP_RST = 4'd2;

    typedef struct packed {
        logic [7:0] coins_per_credit;
        logic       single_mode;
        logic       once_only;
        logic       always_on;
        logic [7:0] blink_frames;
        logic [3:0] buttons_in_group;
    } cfg_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [2:0] group_index;
        logic [2:0] button_index;
    } in_t;

    typedef struct packed {
        logic [2:0] group_out;
        logic [7:0] active_mask;
        logic [7:0] blinking_mask;
        logic [7:0] coin_count_out;
        logic       credit_issued;
        logic       lamp_phase_on;
    } out_t;

    // Outcome of a press on one group
    typedef struct packed {
        logic       hit;        // press changes the group's state
        logic       credit;     // press completed a credit
        logic [7:0] count;      // new coin count
    } press_status_t;

endpackage

// ===== design/ccl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ccl_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module ccl_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ccl_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ccl_pkg::cfg_t                      cfg
);

    ccl_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coins_per_credit <= ccl_pkg::COINS_PER_CREDIT_RST;
            cfg_reg.single_mode      <= 1'b0;
            cfg_reg.once_only        <= 1'b0;
            cfg_reg.always_on        <= 1'b0;
            cfg_reg.blink_frames     <= ccl_pkg::BLINK_FRAMES_RST;
            cfg_reg.buttons_in_group <= ccl_pkg::BUTTONS_IN_GROUP_RST;
        end
        else if (cfg_valid)
        begin
            case (ccl_pkg::cfg_index_t'(cfg_index))
                ccl_pkg::CFG_COINS_PER_CREDIT: cfg_reg.coins_per_credit <= cfg_data;
                ccl_pkg::CFG_SINGLE_MODE:      cfg_reg.single_mode      <= cfg_data[0];
                ccl_pkg::CFG_ONCE_ONLY:        cfg_reg.once_only        <= cfg_data[0];
                ccl_pkg::CFG_ALWAYS_ON:        cfg_reg.always_on        <= cfg_data[0];
                ccl_pkg::CFG_BLINK_FRAMES:     cfg_reg.blink_frames     <= cfg_data;
                ccl_pkg::CFG_BUTTONS_IN_GROUP: cfg_reg.buttons_in_group <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== design/ccl_press_logic.sv =====
// ----------------------------------------------------------------------------
// ccl_press_logic
// Combinational update of one group's masks and coin count for a press.
// ----------------------------------------------------------------------------
module ccl_press_logic
#(
    parameter int MAX_BUTTONS = ccl_pkg::MAX_BUTTONS_DEFAULT
)
(
    input  logic [MAX_BUTTONS-1:0]  act_cur,
    input  logic [MAX_BUTTONS-1:0]  blink_cur,
    input  logic [7:0]              count_cur,
    input  logic [2:0]              button,
    input  ccl_pkg::cfg_t           cfg,
    output logic [MAX_BUTTONS-1:0]  act_new,
    output logic [MAX_BUTTONS-1:0]  blink_new,
    output ccl_pkg::press_status_t  status
);

    logic [4:0]             n;          // clamped group size
    logic [MAX_BUTTONS-1:0] bsel;
    logic [MAX_BUTTONS-1:0] first_oh;
    logic                   found;
    logic                   two_off;
    logic                   all_on;
    logic                   b_ok;
    logic                   hit;
    logic [7:0]             cnt_inc;
    logic                   credit;

    always_comb
    begin
        if (cfg.buttons_in_group < 4'd2)
            n = 5'd2;
        else if ({1'b0, cfg.buttons_in_group} > 5'(MAX_BUTTONS))
            n = 5'(MAX_BUTTONS);
        else
            n = {1'b0, cfg.buttons_in_group};
    end

    always_comb
    begin
        for (int i = 0; i < MAX_BUTTONS; i++)
            bsel[i] = (i == int'(button));
    end

    // first inactive start within the group, and whether two or more are off
    always_comb
    begin
        first_oh = '0;
        found    = 1'b0;
        two_off  = 1'b0;
        for (int c = 1; c < MAX_BUTTONS; c++)
        begin
            if (c < int'(n) && !act_cur[c])
            begin
                if (found)
                    two_off = 1'b1;
                else
                    first_oh[c] = 1'b1;
                found = 1'b1;
            end
        end
        all_on = !two_off;
    end

    assign b_ok    = {2'b00, button} < n;
    assign hit     = b_ok && |(act_cur & bsel);
    assign cnt_inc = count_cur + 8'd1;
    assign credit  = hit && (button == 3'd0) && (cnt_inc >= cfg.coins_per_credit);

    always_comb
    begin
        act_new   = act_cur;
        blink_new = blink_cur;
        if (button == 3'd0)
        begin
            if (credit)
            begin
                if (!cfg.always_on && (cfg.single_mode || all_on))
                begin
                    blink_new[0] = 1'b0;
                    if (!cfg.single_mode || all_on)
                        act_new[0] = 1'b0;
                end
                act_new   = act_new | first_oh;
                blink_new = blink_new | first_oh;
            end
        end
        else
        begin
            act_new   = act_cur & ~bsel;
            blink_new = blink_cur & ~bsel;
            if (!cfg.once_only && !cfg.always_on)
            begin
                act_new[0]   = 1'b1;
                blink_new[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        status.hit    = hit;
        status.credit = credit;
        if (button == 3'd0)
            status.count = credit ? 8'd0 : cnt_inc;
        else
            status.count = count_cur;
    end

endmodule

// ===== design/coin_credit_lamp_controller.sv =====
// ----------------------------------------------------------------------------
// coin_credit_lamp_controller
// Coin and start lamp controller for arcade panels, one report per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per item (press, frame tick, activate, deactivate).
//   out_* : one transaction per item, reporting the addressed group's masks,
//           coin count, credit flag and the current blink phase.
//   cfg_* : register writes, index 0..5; always ready. Write only while idle.
// Timing:
//   An item is captured in the input register, then processed by the press
//   logic and the per-group state registers, with the report loaded into the
//   output register, which drives out_valid. One item per cycle is sustained
//   while the output register is not stalled.
// Reset:
//   rst_n clears all masks, coin counters, the frame divider and the phase,
//   and loads the register defaults. No sweep is needed.
// Stalls:
//   While out_ready is low the output register holds; one more item can wait
//   in the input register, after which in_ready drops until the report moves.
// ----------------------------------------------------------------------------
module coin_credit_lamp_controller
#(
    parameter int GROUPS      = ccl_pkg::GROUPS_DEFAULT,
    parameter int MAX_BUTTONS = ccl_pkg::MAX_BUTTONS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ccl_pkg::in_t                       in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ccl_pkg::out_t                      out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ccl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    ccl_pkg::cfg_t cfg;

    // Input register
    logic          in_valid_reg;
    ccl_pkg::in_t  in_reg;

    // Output register
    logic          out_valid_reg;
    ccl_pkg::out_t out_reg;

    // Per-group and shared state
    logic [MAX_BUTTONS-1:0] act_reg   [GROUPS];
    logic [MAX_BUTTONS-1:0] blink_reg [GROUPS];
    logic [7:0]             count_reg [GROUPS];
    logic [7:0]             frame_reg;
    logic                   phase_reg;
    logic [7:0]             frame_next;
    logic                   phase_next;

    logic                   advance;    // output register free to load
    logic                   work;       // item processed this cycle
    logic [7:0]             g_wide;
    logic [GW-1:0]          g_idx;
    logic                   g_ok;
    logic                   do_press;

    logic [MAX_BUTTONS-1:0] sel_act;
    logic [MAX_BUTTONS-1:0] sel_blink;
    logic [7:0]             sel_count;
    logic [MAX_BUTTONS-1:0] act_new;
    logic [MAX_BUTTONS-1:0] blink_new;
    ccl_pkg::press_status_t status;

    logic [MAX_BUTTONS-1:0] rep_act;
    logic [MAX_BUTTONS-1:0] rep_blink;
    logic [7:0]             rep_count;
    logic [ccl_pkg::MAX_BUTTONS_LIMIT-1:0] act_pad;
    logic [ccl_pkg::MAX_BUTTONS_LIMIT-1:0] blink_pad;
    ccl_pkg::out_t          out_next;

    ccl_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ---- handshake -------------------------------------------------------
    assign advance   = !out_valid_reg || out_ready;
    assign work      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_data;
    end

    // ---- group selection -------------------------------------------------
    assign g_wide   = 8'(in_reg.group_index);
    assign g_idx    = g_wide[GW-1:0];
    assign g_ok     = 32'(in_reg.group_index) < 32'(GROUPS);
    assign do_press = work && g_ok && (in_reg.opcode == ccl_pkg::OP_PRESS) && status.hit;

    // Out-of-range groups are masked here so the array is never read past its end
    always_comb
    begin
        if (g_ok)
        begin
            sel_act   = act_reg[g_idx];
            sel_blink = blink_reg[g_idx];
            sel_count = count_reg[g_idx];
        end
        else
        begin
            sel_act   = '0;
            sel_blink = '0;
            sel_count = '0;
        end
    end

    ccl_press_logic
    #(
        .MAX_BUTTONS (MAX_BUTTONS)
    )
    u_press_logic
    (
        .act_cur   (sel_act),
        .blink_cur (sel_blink),
        .count_cur (sel_count),
        .button    (in_reg.button_index),
        .cfg       (cfg),
        .act_new   (act_new),
        .blink_new (blink_new),
        .status    (status)
    );

    // ---- blink divider ---------------------------------------------------
    always_comb
    begin
        frame_next = frame_reg;
        phase_next = phase_reg;
        if (work && in_reg.opcode == ccl_pkg::OP_TICK)
        begin
            if (frame_reg == cfg.blink_frames)
            begin
                frame_next = 8'd0;
                phase_next = !phase_reg;
            end
            else
                frame_next = frame_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= 8'd0;
            phase_reg <= 1'b0;
        end
        else
        begin
            frame_reg <= frame_next;
            phase_reg <= phase_next;
        end
    end

    // ---- per-group state -------------------------------------------------
    // activate and deactivate touch every group at once; a press only its own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int gi = 0; gi < GROUPS; gi++)
            begin
                act_reg[gi]   <= '0;
                blink_reg[gi] <= '0;
                count_reg[gi] <= 8'd0;
            end
        end
        else if (work)
        begin
            for (int gi = 0; gi < GROUPS; gi++)
            begin
                case (in_reg.opcode)
                    ccl_pkg::OP_PRESS:
                    begin
                        if (do_press && g_idx == GW'(gi))
                        begin
                            act_reg[gi]   <= act_new;
                            blink_reg[gi] <= blink_new;
                            count_reg[gi] <= status.count;
                        end
                    end
                    ccl_pkg::OP_TICK:
                    begin
                    end
                    ccl_pkg::OP_ACTIVATE:
                    begin
                        act_reg[gi]      <= MAX_BUTTONS'(1);
                        blink_reg[gi][0] <= 1'b1;
                    end
                    ccl_pkg::OP_DEACTIVATE:
                    begin
                        act_reg[gi]   <= '0;
                        blink_reg[gi] <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ---- report of the addressed group after the update -------------------
    always_comb
    begin
        rep_act   = sel_act;
        rep_blink = sel_blink;
        rep_count = sel_count;
        case (in_reg.opcode)
            ccl_pkg::OP_PRESS:
            begin
                if (status.hit)
                begin
                    rep_act   = act_new;
                    rep_blink = blink_new;
                    rep_count = status.count;
                end
            end
            ccl_pkg::OP_TICK:
            begin
            end
            ccl_pkg::OP_ACTIVATE:
            begin
                rep_act      = MAX_BUTTONS'(1);
                rep_blink[0] = 1'b1;
            end
            ccl_pkg::OP_DEACTIVATE:
            begin
                rep_act   = '0;
                rep_blink = '0;
            end
            default:
            begin
            end
        endcase
        if (!g_ok)
        begin
            rep_act   = '0;
            rep_blink = '0;
            rep_count = 8'd0;
        end
    end

    always_comb
    begin
        act_pad                   = '0;
        blink_pad                 = '0;
        act_pad[MAX_BUTTONS-1:0]  = rep_act;
        blink_pad[MAX_BUTTONS-1:0] = rep_blink;

        out_next.group_out      = in_reg.group_index;
        out_next.active_mask    = act_pad[7:0];
        out_next.blinking_mask  = blink_pad[7:0];
        out_next.coin_count_out = rep_count;
        out_next.credit_issued  = g_ok && (in_reg.opcode == ccl_pkg::OP_PRESS) && status.credit;
        out_next.lamp_phase_on  = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (work)
            out_reg <= out_next;
    end

    // ---- assertions ------------------------------------------------------
    // a held item is not lost or altered while the report waits
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("input register changed while stalled");

    // a credit always leaves the coin counter cleared
    a_credit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.credit_issued |-> out_data.coin_count_out == 8'd0)
        else $error("credit reported with non-zero coin count");

    // the phase only turns over with the frame divider at zero
    a_phase_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != $past(phase_reg) |-> frame_reg == 8'd0)
        else $error("blink phase toggled without divider wrap");

    // the blink divider and phase change only when an item is processed
    a_frame_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !work |=> $stable(frame_reg) && $stable(phase_reg))
        else $error("blink divider moved without an item");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coin and start lamp controller. A behavioural
// copy of the lamp state forecasts the report of every accepted transaction;
// a monitor compares each report field by field, in order, under random
// gaps on both channels, a long output hold-off and several register setups.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          NUM_GROUPS  = ccl_pkg::GROUPS_DEFAULT;
    localparam int          NUM_BUTTONS = ccl_pkg::MAX_BUTTONS_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 120;
    localparam int          IDLE_PCT    = 34;

    // Clock and reset
    logic clk;
    logic rst_n = 1'b0;

    // Item channel
    logic          in_valid = 1'b0;
    logic          in_ready;
    ccl_pkg::in_t  in_data  = '0;

    // Report channel
    logic          out_valid;
    logic          out_ready = 1'b0;
    ccl_pkg::out_t out_data;

    // Register write channel
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ccl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ccl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    coin_credit_lamp_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Forecast state: a private copy of the registers and the lamp state.
    // Reset only happens once, so the declaration values are the reset values.
    // ------------------------------------------------------------------------
    logic [7:0] credit_price = ccl_pkg::COINS_PER_CREDIT_RST;
    logic       single_cfg   = 1'b0;
    logic       once_cfg     = 1'b0;
    logic       always_cfg   = 1'b0;
    logic [7:0] blink_period = ccl_pkg::BLINK_FRAMES_RST;
    logic [3:0] group_width  = ccl_pkg::BUTTONS_IN_GROUP_RST;

    logic [7:0] lamp_active [NUM_GROUPS] = '{default: '0};
    logic [7:0] lamp_blink  [NUM_GROUPS] = '{default: '0};
    logic [7:0] coin_tally  [NUM_GROUPS] = '{default: '0};
    logic [7:0] frame_div   = '0;
    logic       blink_phase = 1'b0;

    ccl_pkg::out_t reports_due [$];      // forecast reports, oldest first
    int   fault_count = 0;
    bit   calm        = 1'b0;   // no idling on either side while set
    int   hold_asked  = 0;      // bumped by a test to ask for an output hold-off
    int   hold_granted = 0;
    int   hold_left   = 0;
    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost report ends the run here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("coin_credit_lamp_controller: mismatch");
        $finish;
    end

    // Buttons in use per group, clamped to 2..NUM_BUTTONS
    function automatic int unsigned group_buttons();
        int unsigned n;
        n = group_width;
        if (n < 2)
            n = 2;
        if (n > NUM_BUTTONS)
            n = NUM_BUTTONS;
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // Forecast of one transaction: updates the lamp copy and returns the
    // report the block owes for it.
    // ------------------------------------------------------------------------
    function automatic ccl_pkg::out_t next_report(input ccl_pkg::in_t item);
        ccl_pkg::out_t rep;
        int unsigned   n;
        int unsigned   first;
        int unsigned   idle_starts;
        int unsigned   g;
        int unsigned   b;
        logic          credit;
        logic          all_on;
        credit = 1'b0;
        g      = item.group_index;
        b      = item.button_index;
        n      = group_buttons();
        case (item.opcode)
            ccl_pkg::OP_PRESS:
            begin
                // presses beyond the group size or on a dark button do nothing
                if (b < n && lamp_active[g][b])
                begin
                    if (b == 0)
                    begin
                        coin_tally[g] = coin_tally[g] + 8'd1;
                        if (coin_tally[g] >= credit_price)
                        begin
                            coin_tally[g] = '0;
                            credit        = 1'b1;
                            first         = 0;
                            idle_starts   = 0;
                            for (int unsigned c = 1; c < n; c++)
                            begin
                                if (!lamp_active[g][c])
                                begin
                                    if (first == 0)
                                        first = c;
                                    idle_starts++;
                                end
                            end
                            // "all on": at most one start still dark
                            all_on = (idle_starts <= 1);
                            if (!always_cfg && (single_cfg || all_on))
                            begin
                                lamp_blink[g][0] = 1'b0;
                                if (!single_cfg || all_on)
                                    lamp_active[g][0] = 1'b0;
                            end
                            if (first != 0)
                            begin
                                lamp_active[g][first] = 1'b1;
                                lamp_blink[g][first]  = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        lamp_active[g][b] = 1'b0;
                        lamp_blink[g][b]  = 1'b0;
                        if (!once_cfg && !always_cfg)
                        begin
                            lamp_active[g][0] = 1'b1;
                            lamp_blink[g][0]  = 1'b1;
                        end
                    end
                end
            end
            ccl_pkg::OP_TICK:
            begin
                if (frame_div == blink_period)
                begin
                    frame_div   = '0;
                    blink_phase = ~blink_phase;
                end
                else
                    frame_div = frame_div + 8'd1;
            end
            ccl_pkg::OP_ACTIVATE:
            begin
                // start blink flags survive an activate
                for (int i = 0; i < NUM_GROUPS; i++)
                begin
                    lamp_active[i]   = 8'h01;
                    lamp_blink[i][0] = 1'b1;
                end
            end
            default:
            begin
                for (int i = 0; i < NUM_GROUPS; i++)
                begin
                    lamp_active[i] = '0;
                    lamp_blink[i]  = '0;
                end
            end
        endcase
        // group_index is 3 bits wide and all eight groups exist, so the
        // zero report for a missing group cannot arise here
        rep.group_out      = item.group_index;
        rep.active_mask    = lamp_active[g];
        rep.blinking_mask  = lamp_blink[g];
        rep.coin_count_out = coin_tally[g];
        rep.credit_issued  = credit;
        rep.lamp_phase_on  = blink_phase;
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Item driver. Called at a rising edge; returns at the edge the
    // transaction is taken, leaving in_valid high so back-to-back items never
    // see a low-then-high in one step.
    // ------------------------------------------------------------------------
    task automatic offer_item(input ccl_pkg::in_t item);
        if (!calm)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        reports_due.push_back(next_report(item));
    endtask

    task automatic offer(input ccl_pkg::opcode_t op, input int unsigned g,
                         input int unsigned b);
        ccl_pkg::in_t item;
        item.opcode       = op;
        item.group_index  = g[2:0];
        item.button_index = b[2:0];
        offer_item(item);
    endtask

    // Drop valid and let every outstanding report drain, plus the pipeline
    // depth, so a register write lands on an idle block
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // One register write transaction; valid drops on a step of its own
    task automatic write_reg(input ccl_pkg::cfg_index_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            ccl_pkg::CFG_COINS_PER_CREDIT: credit_price = value;
            ccl_pkg::CFG_SINGLE_MODE:      single_cfg   = value[0];
            ccl_pkg::CFG_ONCE_ONLY:        once_cfg     = value[0];
            ccl_pkg::CFG_ALWAYS_ON:        always_cfg   = value[0];
            ccl_pkg::CFG_BLINK_FRAMES:     blink_period = value;
            ccl_pkg::CFG_BUTTONS_IN_GROUP: group_width  = value[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Full register setup; narrow fields get random padding in the unused bits
    task automatic load_setting(input logic [7:0] price, input logic single,
                                input logic once, input logic keep_lit,
                                input logic [7:0] blink, input logic [3:0] width);
        settle();
        write_reg(ccl_pkg::CFG_COINS_PER_CREDIT, price);
        write_reg(ccl_pkg::CFG_SINGLE_MODE,      {7'($urandom), single});
        write_reg(ccl_pkg::CFG_ONCE_ONLY,        {7'($urandom), once});
        write_reg(ccl_pkg::CFG_ALWAYS_ON,        {7'($urandom), keep_lit});
        write_reg(ccl_pkg::CFG_BLINK_FRAMES,     blink);
        write_reg(ccl_pkg::CFG_BUTTONS_IN_GROUP, {4'($urandom), width});
    endtask

    // ------------------------------------------------------------------------
    // Test: presses and ticks on a panel that was never activated
    // ------------------------------------------------------------------------
    task automatic test_dark_panel();
        offer(ccl_pkg::OP_PRESS, 0, 0);
        offer(ccl_pkg::OP_TICK, 7, 7);
        offer(ccl_pkg::OP_PRESS, 7, 1);
    endtask

    // ------------------------------------------------------------------------
    // Test: credit and relight rules across the mode bits
    // ------------------------------------------------------------------------
    task automatic test_credit_rules();
        // reset setup: one coin per credit, multi mode, two buttons
        offer(ccl_pkg::OP_ACTIVATE, 3, 0);
        offer(ccl_pkg::OP_PRESS, 0, 0);      // credit, "all on", coin goes dark
        offer(ccl_pkg::OP_PRESS, 0, 0);      // coin now dark, ignored
        offer(ccl_pkg::OP_PRESS, 0, 1);      // start relights the coin
        offer(ccl_pkg::OP_PRESS, 0, 5);      // beyond the group size
        // wide groups, three coins a credit, single mode
        settle();
        write_reg(ccl_pkg::CFG_BUTTONS_IN_GROUP, 8'd8);
        write_reg(ccl_pkg::CFG_COINS_PER_CREDIT, 8'd3);
        write_reg(ccl_pkg::CFG_SINGLE_MODE, 8'd1);
        offer(ccl_pkg::OP_ACTIVATE, 1, 0);
        repeat (6) offer(ccl_pkg::OP_PRESS, 1, 0);
        offer(ccl_pkg::OP_PRESS, 1, 1);
        offer(ccl_pkg::OP_PRESS, 1, 7);      // still dark
        // no relight after a start
        settle();
        write_reg(ccl_pkg::CFG_ONCE_ONLY, 8'd1);
        offer(ccl_pkg::OP_PRESS, 1, 2);
        // coin always on, every coin a credit
        settle();
        write_reg(ccl_pkg::CFG_ALWAYS_ON, 8'd1);
        write_reg(ccl_pkg::CFG_COINS_PER_CREDIT, 8'd0);
        offer(ccl_pkg::OP_PRESS, 2, 0);
        offer(ccl_pkg::OP_PRESS, 2, 0);
        offer(ccl_pkg::OP_PRESS, 2, 1);
        offer(ccl_pkg::OP_DEACTIVATE, 2, 0);
        offer(ccl_pkg::OP_PRESS, 2, 0);
    endtask

    // ------------------------------------------------------------------------
    // Test: blink divider at its fastest
    // ------------------------------------------------------------------------
    task automatic test_blink_rate();
        settle();
        write_reg(ccl_pkg::CFG_BLINK_FRAMES, 8'd0);
        repeat (3) offer(ccl_pkg::OP_TICK, 4, 0);
    endtask

    // ------------------------------------------------------------------------
    // Test: output held off for a long stretch while items keep coming
    // ------------------------------------------------------------------------
    task automatic test_backpressure();
        calm = 1'b1;
        hold_asked++;
        offer(ccl_pkg::OP_ACTIVATE, 5, 0);
        for (int i = 0; i < 30; i++)
            offer(ccl_pkg::OP_PRESS, $urandom_range(NUM_GROUPS - 1), $urandom_range(1));
        calm = 1'b0;
    endtask

    // Random item: mostly presses on real buttons, some ticks, the odd
    // activate/deactivate and a little out-of-range noise
    function automatic ccl_pkg::in_t random_item(input int unsigned coin_pct,
                                                 input int unsigned span,
                                                 input int unsigned deact_pct);
        ccl_pkg::in_t item;
        int unsigned  r;
        int unsigned  n;
        n                 = group_buttons();
        r                 = $urandom_range(99);
        item.group_index  = 3'($urandom_range(span));
        item.button_index = 3'($urandom);
        if (r < deact_pct)
            item.opcode = ccl_pkg::OP_DEACTIVATE;
        else if (r < deact_pct + 5)
            item.opcode = ccl_pkg::OP_ACTIVATE;
        else if (r < deact_pct + 25)
            item.opcode = ccl_pkg::OP_TICK;
        else
        begin
            item.opcode = ccl_pkg::OP_PRESS;
            if ($urandom_range(99) >= 10)
            begin
                if ($urandom_range(99) < coin_pct)
                    item.button_index = '0;
                else
                    item.button_index = 3'($urandom_range(n - 1, 1));
            end
        end
        return item;
    endfunction

    // ------------------------------------------------------------------------
    // Test: one random phase under a given register setup
    // ------------------------------------------------------------------------
    task automatic test_random_phase(input logic [7:0] price, input logic single,
                                     input logic once, input logic keep_lit,
                                     input logic [7:0] blink, input logic [3:0] width,
                                     input int count, input int unsigned coin_pct,
                                     input int unsigned span, input int unsigned deact_pct);
        load_setting(price, single, once, keep_lit, blink, width);
        offer(ccl_pkg::OP_ACTIVATE, $urandom_range(span), $urandom_range(7));
        for (int i = 0; i < count; i++)
            offer_item(random_item(coin_pct, span, deact_pct));
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready, with a counted hold-off when a test asks
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_granted)
        begin
            hold_granted <= hold_asked;
            hold_left    <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Report monitor: each accepted report against the oldest forecast
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        ccl_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("report transaction with no item outstanding");
                fault_count++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (out_data.group_out !== want.group_out)
                begin
                    $error("group_out: expected %0d, got %0d",
                           want.group_out, out_data.group_out);
                    fault_count++;
                end
                if (out_data.active_mask !== want.active_mask)
                begin
                    $error("active_mask: expected %h, got %h",
                           want.active_mask, out_data.active_mask);
                    fault_count++;
                end
                if (out_data.blinking_mask !== want.blinking_mask)
                begin
                    $error("blinking_mask: expected %h, got %h",
                           want.blinking_mask, out_data.blinking_mask);
                    fault_count++;
                end
                if (out_data.coin_count_out !== want.coin_count_out)
                begin
                    $error("coin_count_out: expected %0d, got %0d",
                           want.coin_count_out, out_data.coin_count_out);
                    fault_count++;
                end
                if (out_data.credit_issued !== want.credit_issued)
                begin
                    $error("credit_issued: expected %b, got %b",
                           want.credit_issued, out_data.credit_issued);
                    fault_count++;
                end
                if (out_data.lamp_phase_on !== want.lamp_phase_on)
                begin
                    $error("lamp_phase_on: expected %b, got %b",
                           want.lamp_phase_on, out_data.lamp_phase_on);
                    fault_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_dark_panel();
        test_credit_rules();
        test_blink_rate();
        test_backpressure();

        // price, single, once, always, blink, width, items, coin %, span, deact %
        test_random_phase(8'd1,   1'b0, 1'b0, 1'b0, 8'd6,   4'd2,  175, 50, 7, 3);
        test_random_phase(8'd0,   1'b1, 1'b0, 1'b0, 8'd0,   4'd8,  175, 45, 7, 3);
        calm = 1'b1;    // long stretch with no gaps on either side
        test_random_phase(8'd3,   1'b0, 1'b1, 1'b0, 8'd2,   4'd5,  175, 60, 3, 2);
        calm = 1'b0;
        test_random_phase(8'd2,   1'b1, 1'b1, 1'b0, 8'd1,   4'd15, 175, 50, 7, 3);
        // slowest divider and dearest credit: one group, nearly all coins
        test_random_phase(8'd255, 1'b0, 1'b0, 1'b1, 8'd255, 4'd0,  480, 90, 0, 0);
        test_random_phase(8'd4,   1'b1, 1'b0, 1'b1, 8'd3,   4'd7,  175, 55, 7, 3);
        test_random_phase(8'd1,   1'b0, 1'b0, 1'b0, 8'd0,   4'd3,  175, 50, 7, 4);
        test_random_phase(8'd2,   1'b0, 1'b1, 1'b1, 8'd4,   4'd1,  175, 50, 7, 3);

        settle();
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("coin_credit_lamp_controller: match");
        else
            $display("coin_credit_lamp_controller: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ccl_pkg.sv
design/ccl_cfg_regs.sv
design/ccl_press_logic.sv
design/coin_credit_lamp_controller.sv
verif/tb_top.sv
